@@ rtl/rpmqf_pkg.sv @@
// Shared types, constants and field codes of the read-pair mean quality filter.
package rpmqf_pkg;

	localparam int LANE_SLOTS      = 8;
	localparam int SIDES           = 4;
	localparam int SWATCHES        = 4;
	localparam int TILES           = 32;
	localparam int MAX_READ_LENGTH = 1024;

	localparam int CLASS_COUNT = 4;
	localparam int STORE_DEPTH = LANE_SLOTS * SIDES * SWATCHES * TILES * CLASS_COUNT;
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam int CNT_W       = 32;
	localparam int MARGIN_W    = 24;
	localparam int Q_DEPTH     = 4;
	localparam int Q_PTR_W     = $clog2(Q_DEPTH);

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [1:0] {
		MODE_FWD  = 2'd0,
		MODE_REV  = 2'd1,
		MODE_EOR  = 2'd2,
		MODE_READ = 2'd3
	} mode_t;

	typedef enum logic {
		KIND_DECISION = 1'b0,
		KIND_READBACK = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		CLS_BOTH    = 2'd0,
		CLS_FWD     = 2'd1,
		CLS_REV     = 2'd2,
		CLS_DISCARD = 2'd3
	} cls_t;

	typedef enum logic [1:0] {
		REG_SINGLE_END = 2'd0,
		REG_QUAL_BASE  = 2'd1,
		REG_KEEP_LEVEL = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic       single_end;
		logic [6:0] qual_base;
		logic [6:0] keep_level;
	} cfg_t;

	typedef struct packed {
		kind_t            kind;
		cls_t             cls;
		logic             hit;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

endpackage

@@ rtl/read_pair_mean_quality_filter_core.sv @@
// Top level of the read-pair mean quality filter with per-tile counters.
// Each quality byte adds (byte - offset - threshold) to its read's saturating
// 24-bit margin; an end-of-record item classifies the pair or single read,
// bumps the saturating 32-bit counter for its lane, tile and class, and
// returns the class. A read-back item returns one counter. The block takes
// one item per cycle while the command queue has room; end-of-record and
// read-back items queue for the counter RAM (16384 x 32, one write and one
// registered read port), where each read-modify-write bypasses the last write.
// A result passes through the command queue, the RAM read stage and the
// output register. After reset the counter RAM is cleared, during which
// s_axis_tready stays low; configuration writes are taken at any time.
module read_pair_mean_quality_filter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// quality_char[7:0], lane_slot[10:8], tile_side[12:11], tile_swatch[14:13],
	// tile_number[19:15], query_class[21:20], zero fill [23:22]
	input  logic [23:0] s_axis_tdata,
	// mode[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// decision[1:0], counter_value[33:2], zero fill [39:34]
	output logic [39:0] m_axis_tdata,
	// result_kind[0]
	output logic [0:0]  m_axis_tuser
);

	import rpmqf_pkg::*;

	cfg_t       cfg;
	back_stat_t stat;
	logic       q_full;
	logic       q_push;
	cmd_t       q_cmd;
	logic       q_pop;
	logic       head_valid;
	cmd_t       head_cmd;

	rpmqf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rpmqf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.stat          (stat),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_cmd         (q_cmd)
	);

	rpmqf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	rpmqf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_cmd      (head_cmd),
		.pop           (q_pop),
		.stat          (stat),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

`ifndef NO_ASSERTIONS
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !s_axis_tready)
		else $error("item accepted during counter clear");

	a_no_queue_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("command queue overflow");

	a_no_pop_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !q_pop)
		else $error("command taken during counter clear");

	a_decision_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser[0] == KIND_DECISION)) |-> (m_axis_tdata[33:2] == '0))
		else $error("record decision carries a counter value");
`endif

endmodule

@@ rtl/rpmqf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rpmqf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/rpmqf_cfg.sv @@
// APB configuration registers of the quality filter.
module rpmqf_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output rpmqf_pkg::cfg_t     cfg
);

	import rpmqf_pkg::*;

	cfg_t cfg_q;
	logic wr;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.single_end <= 1'b0;
			cfg_q.qual_base  <= 7'd33;
			cfg_q.keep_level <= 7'd20;
		end else if (wr) begin
			case (paddr[3:2])
				REG_SINGLE_END: cfg_q.single_end <= pwdata[0];
				REG_QUAL_BASE:  cfg_q.qual_base  <= pwdata[6:0];
				REG_KEEP_LEVEL: cfg_q.keep_level <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SINGLE_END: prdata = {31'd0, cfg_q.single_end};
			REG_QUAL_BASE:  prdata = {25'd0, cfg_q.qual_base};
			REG_KEEP_LEVEL: prdata = {25'd0, cfg_q.keep_level};
			default:        prdata = 32'd0;
		endcase
	end

endmodule

@@ rtl/rpmqf_front.sv @@
// Front end: accepts items, accumulates read margins, classifies records.
module rpmqf_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rpmqf_pkg::cfg_t       cfg,
	input  rpmqf_pkg::back_stat_t stat,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [23:0]           s_axis_tdata,
	input  logic [1:0]            s_axis_tuser,
	input  logic                  q_full,
	output logic                  q_push,
	output rpmqf_pkg::cmd_t       q_cmd
);

	import rpmqf_pkg::*;

	logic                       accept;
	mode_t                      mode;
	logic [7:0]                 quality_char;
	logic [2:0]                 lane_slot;
	logic [1:0]                 tile_side;
	logic [1:0]                 tile_swatch;
	logic [4:0]                 tile_number;
	logic [1:0]                 query_class;
	logic signed [MARGIN_W-1:0] fwd_margin_q;
	logic signed [MARGIN_W-1:0] rev_margin_q;
	logic                       fwd_seen_q;
	logic                       rev_seen_q;
	logic signed [9:0]          delta;
	logic signed [MARGIN_W-1:0] fwd_next;
	logic signed [MARGIN_W-1:0] rev_next;
	logic                       fwd_ok;
	logic                       rev_ok;
	cls_t                       rec_cls;
	cls_t                       cls;
	logic                       hit;
	logic [31:0]                idx_full;

	function automatic logic signed [MARGIN_W-1:0] sat_add(
		input logic signed [MARGIN_W-1:0] margin,
		input logic signed [9:0]          d
	);
		logic signed [MARGIN_W:0] sum;
		sum = {margin[MARGIN_W-1], margin} + {{(MARGIN_W-9){d[9]}}, d};
		if (sum[MARGIN_W] != sum[MARGIN_W-1]) begin
			sat_add = sum[MARGIN_W] ? {1'b1, {(MARGIN_W-1){1'b0}}}
			                        : {1'b0, {(MARGIN_W-1){1'b1}}};
		end else begin
			sat_add = sum[MARGIN_W-1:0];
		end
	endfunction

	assign mode         = mode_t'(s_axis_tuser);
	assign quality_char = s_axis_tdata[7:0];
	assign lane_slot    = s_axis_tdata[10:8];
	assign tile_side    = s_axis_tdata[12:11];
	assign tile_swatch  = s_axis_tdata[14:13];
	assign tile_number  = s_axis_tdata[19:15];
	assign query_class  = s_axis_tdata[21:20];

	assign s_axis_tready = !stat.clearing && !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign delta = $signed({2'b00, quality_char}) - $signed({3'b000, cfg.qual_base})
	               - $signed({3'b000, cfg.keep_level});
	assign fwd_next = sat_add(fwd_margin_q, delta);
	assign rev_next = sat_add(rev_margin_q, delta);

	assign fwd_ok = fwd_seen_q && !fwd_margin_q[MARGIN_W-1];
	assign rev_ok = rev_seen_q && !rev_margin_q[MARGIN_W-1];

	always_comb begin
		if (cfg.single_end) begin
			rec_cls = fwd_ok ? CLS_BOTH : CLS_DISCARD;
		end else if (fwd_ok && rev_ok) begin
			rec_cls = CLS_BOTH;
		end else if (fwd_ok) begin
			rec_cls = CLS_FWD;
		end else if (rev_ok) begin
			rec_cls = CLS_REV;
		end else begin
			rec_cls = CLS_DISCARD;
		end
	end

	assign cls = (mode == MODE_READ) ? cls_t'(query_class) : rec_cls;
	assign hit = (32'(lane_slot) < LANE_SLOTS) && (32'(tile_side) < SIDES)
	             && (32'(tile_swatch) < SWATCHES) && (32'(tile_number) < TILES);
	assign idx_full = (((32'(lane_slot) * SIDES + 32'(tile_side)) * SWATCHES
	                  + 32'(tile_swatch)) * TILES + 32'(tile_number)) * CLASS_COUNT
	                  + 32'(cls);

	always_comb begin
		q_cmd.kind = (mode == MODE_READ) ? KIND_READBACK : KIND_DECISION;
		q_cmd.cls  = cls;
		q_cmd.hit  = hit;
		q_cmd.idx  = idx_full[IDX_W-1:0];
		q_push     = accept && ((mode == MODE_EOR) || (mode == MODE_READ));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_margin_q <= '0;
			rev_margin_q <= '0;
			fwd_seen_q   <= 1'b0;
			rev_seen_q   <= 1'b0;
		end else if (accept) begin
			case (mode)
				MODE_FWD: begin
					fwd_margin_q <= fwd_next;
					fwd_seen_q   <= 1'b1;
				end
				MODE_REV: begin
					rev_margin_q <= rev_next;
					rev_seen_q   <= 1'b1;
				end
				MODE_EOR: begin
					fwd_margin_q <= '0;
					rev_margin_q <= '0;
					fwd_seen_q   <= 1'b0;
					rev_seen_q   <= 1'b0;
				end
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/rpmqf_queue.sv @@
// Short command queue between the front end and the counter back end.
module rpmqf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rpmqf_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output rpmqf_pkg::cmd_t head_cmd
);

	import rpmqf_pkg::*;

	cmd_t               buf_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full       = (count_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = buf_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/rpmqf_back.sv @@
// Back end: counter store clear, read-modify-write and output register.
module rpmqf_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  rpmqf_pkg::cmd_t       head_cmd,
	output logic                  pop,
	output rpmqf_pkg::back_stat_t stat,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [39:0]           m_axis_tdata,
	output logic [0:0]            m_axis_tuser
);

	import rpmqf_pkg::*;

	logic             clearing_q;
	logic [IDX_W-1:0] clr_addr_q;
	logic             adv;
	logic             s1_valid_s1;
	cmd_t             cmd_s1;
	logic [CNT_W-1:0] rdata;
	logic [CNT_W-1:0] cur;
	logic [CNT_W-1:0] inc;
	logic             item_we;
	logic             fwd_valid_q;
	logic [IDX_W-1:0] fwd_idx_q;
	logic [CNT_W-1:0] fwd_data_q;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [CNT_W-1:0] ram_wdata;
	logic             out_valid_q;
	kind_t            out_kind_q;
	cls_t             out_cls_q;
	logic [CNT_W-1:0] out_value_q;

	assign stat.clearing = clearing_q;
	assign adv           = !out_valid_q || m_axis_tready;
	assign pop           = adv && head_valid && !clearing_q;

	assign cur     = (fwd_valid_q && (fwd_idx_q == cmd_s1.idx)) ? fwd_data_q : rdata;
	assign inc     = (cur == CNT_MAX) ? cur : cur + 1'b1;
	assign item_we = adv && s1_valid_s1 && (cmd_s1.kind == KIND_DECISION) && cmd_s1.hit;

	always_comb begin
		if (clearing_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = item_we;
			ram_waddr = cmd_s1.idx;
			ram_wdata = inc;
		end
	end

	rpmqf_ram #(
		.WIDTH (CNT_W),
		.DEPTH (STORE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (pop),
		.raddr (head_cmd.idx),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == IDX_W'(STORE_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			fwd_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			s1_valid_s1 <= pop;
			fwd_valid_q <= item_we;
			out_valid_q <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1      <= head_cmd;
			fwd_idx_q   <= cmd_s1.idx;
			fwd_data_q  <= inc;
			out_kind_q  <= cmd_s1.kind;
			out_cls_q   <= cmd_s1.cls;
			out_value_q <= ((cmd_s1.kind == KIND_READBACK) && cmd_s1.hit) ? cur : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tdata  = {6'd0, out_value_q, out_cls_q};

endmodule

@@ dv/read_pair_mean_quality_filter_core_test.sv @@
`timescale 1ns / 100ps
// Testbench for read_pair_mean_quality_filter_core: directed and random items checked by a predictor.
module read_pair_mean_quality_filter_core_test;
	import rpmqf_pkg::*;

	localparam int RANDOM_ITEMS  = 420;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 3 * STORE_DEPTH;
	localparam int REG_UNMAPPED  = 3;
	localparam int MARGIN_MAX    = 2 ** (MARGIN_W - 1) - 1;
	localparam int MARGIN_MIN    = -(2 ** (MARGIN_W - 1));

	typedef struct packed {
		logic [4:0] tile;
		logic [1:0] swatch;
		logic [1:0] side;
		logic [2:0] lane;
	} tile_pos_t;

	typedef struct packed {
		kind_t            kind;
		cls_t             decision;
		logic [CNT_W-1:0] count;
	} result_t;

	localparam tile_pos_t TILE_FIRST = '0;
	localparam tile_pos_t TILE_LAST  = '1;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;

	cfg_t           cfg_mirror;
	int             fwd_margin;
	int             rev_margin;
	bit             fwd_seen;
	bit             rev_seen;
	bit [CNT_W-1:0] tile_count [STORE_DEPTH];
	result_t        pending_results[$];
	tile_pos_t      tile_pool[$];
	int             mismatch_count;
	bit             tx_gaps_on;
	bit             rx_gaps_on;
	bit             hold_request;

	read_pair_mean_quality_filter_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin : clock_gen
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int add_margin(int margin, logic [7:0] q);
		int qv;
		int off;
		int thr;
		int sum;
		qv  = q;
		off = cfg_mirror.qual_base;
		thr = cfg_mirror.keep_level;
		sum = margin + qv - off - thr;
		if (sum > MARGIN_MAX)
			sum = MARGIN_MAX;
		if (sum < MARGIN_MIN)
			sum = MARGIN_MIN;
		return sum;
	endfunction

	function automatic void predict_item(mode_t m, logic [23:0] d);
		tile_pos_t  p;
		logic [1:0] qc;
		bit         in_range;
		bit         fwd_ok;
		bit         rev_ok;
		int         slot;
		cls_t       c;
		result_t    r;
		p  = d[19:8];
		qc = d[21:20];
		in_range = p.lane < LANE_SLOTS && p.side < SIDES && p.swatch < SWATCHES
			&& p.tile < TILES;
		slot = (((int'(p.lane) * SIDES + p.side) * SWATCHES + p.swatch) * TILES + p.tile)
			* CLASS_COUNT;
		case (m)
			MODE_FWD: begin
				fwd_margin = add_margin(fwd_margin, d[7:0]);
				fwd_seen   = 1'b1;
			end
			MODE_REV: begin
				rev_margin = add_margin(rev_margin, d[7:0]);
				rev_seen   = 1'b1;
			end
			MODE_EOR: begin
				fwd_ok = fwd_seen && fwd_margin >= 0;
				rev_ok = rev_seen && rev_margin >= 0;
				if (cfg_mirror.single_end) begin
					if (fwd_ok)
						c = CLS_BOTH;
					else
						c = CLS_DISCARD;
				end else if (fwd_ok && rev_ok) begin
					c = CLS_BOTH;
				end else if (fwd_ok) begin
					c = CLS_FWD;
				end else if (rev_ok) begin
					c = CLS_REV;
				end else begin
					c = CLS_DISCARD;
				end
				if (in_range && tile_count[slot + c] != CNT_MAX)
					tile_count[slot + c] += 1;
				fwd_margin = 0;
				rev_margin = 0;
				fwd_seen   = 1'b0;
				rev_seen   = 1'b0;
				r.kind     = KIND_DECISION;
				r.decision = c;
				r.count    = '0;
				pending_results.push_back(r);
			end
			default: begin
				r.kind     = KIND_READBACK;
				r.decision = cls_t'(qc);
				r.count    = '0;
				if (in_range)
					r.count = tile_count[slot + qc];
				pending_results.push_back(r);
			end
		endcase
	endfunction

	task automatic send_item(mode_t m, logic [23:0] d);
		int gap;
		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		s_axis_tuser  <= m;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_item(m, d);
	endtask

	task automatic send_byte(mode_t m, logic [7:0] q);
		logic [13:0] junk;
		junk = 14'($urandom);
		send_item(m, {2'b00, junk, q});
	endtask

	task automatic send_tile(mode_t m, tile_pos_t p, logic [1:0] qc);
		logic [7:0] q;
		q = 8'($urandom);
		send_item(m, {2'b00, qc, p, q});
	endtask

	// Hold the input, drain all results, then let the pipeline settle.
	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(int index, logic [31:0] value);
		quiesce();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 4'(index * 4);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (index)
			REG_SINGLE_END: cfg_mirror.single_end = value[0];
			REG_QUAL_BASE:  cfg_mirror.qual_base = value[6:0];
			REG_KEEP_LEVEL: cfg_mirror.keep_level = value[6:0];
			default: ;
		endcase
	endtask

	function automatic tile_pos_t rand_tile();
		tile_pos_t p;
		p.lane   = 3'($urandom_range(0, 7));
		p.side   = 2'($urandom_range(0, 3));
		p.swatch = 2'($urandom_range(0, 3));
		p.tile   = 5'($urandom_range(0, 31));
		return p;
	endfunction

	function automatic tile_pos_t pool_tile();
		return tile_pool[$urandom_range(0, tile_pool.size() - 1)];
	endfunction

	function automatic logic [7:0] near_byte(int spread);
		int v;
		if ($urandom_range(0, 6) == 0)
			return 8'($urandom_range(0, 255));
		v = int'(cfg_mirror.qual_base) + int'(cfg_mirror.keep_level)
			+ int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return 8'(v);
	endfunction

	function automatic int pick_level(int usual);
		case ($urandom_range(0, 4))
			0: return 0;
			1: return 127;
			2: return usual;
			default: return $urandom_range(0, 127);
		endcase
	endfunction

	task automatic send_record(int fwd_len, int rev_len, int spread, tile_pos_t p);
		for (int i = 0; i < fwd_len; i++)
			send_byte(MODE_FWD, near_byte(spread));
		for (int i = 0; i < rev_len; i++)
			send_byte(MODE_REV, near_byte(spread));
		send_tile(MODE_EOR, p, 2'($urandom_range(0, 3)));
	endtask

	task automatic test_directed_classes();
		// empty pair
		send_tile(MODE_EOR, TILE_FIRST, CLS_BOTH);
		send_tile(MODE_READ, TILE_FIRST, CLS_DISCARD);
		// forward mean exactly at threshold, reverse one below
		send_byte(MODE_FWD, 8'd53);
		send_byte(MODE_REV, 8'd52);
		send_tile(MODE_EOR, TILE_LAST, CLS_BOTH);
		send_byte(MODE_FWD, 8'd0);
		send_byte(MODE_REV, 8'd255);
		send_tile(MODE_EOR, TILE_LAST, CLS_DISCARD);
		send_byte(MODE_FWD, 8'd255);
		send_byte(MODE_REV, 8'd53);
		send_tile(MODE_EOR, TILE_LAST, CLS_FWD);
		send_byte(MODE_REV, 8'd0);
		send_byte(MODE_FWD, 8'd255);
		send_byte(MODE_FWD, 8'd0);
		send_tile(MODE_EOR, TILE_LAST, CLS_REV);
		// empty reverse read
		send_byte(MODE_FWD, 8'd100);
		send_tile(MODE_EOR, TILE_LAST, CLS_BOTH);
		for (int c = 0; c < CLASS_COUNT; c++)
			send_tile(MODE_READ, TILE_LAST, 2'(c));
	endtask

	task automatic test_register_settings();
		write_reg(REG_SINGLE_END, 32'd1);
		send_byte(MODE_FWD, 8'd60);
		send_byte(MODE_REV, 8'd0);
		send_tile(MODE_EOR, TILE_FIRST, CLS_BOTH);
		send_byte(MODE_FWD, 8'd10);
		send_byte(MODE_REV, 8'd255);
		send_tile(MODE_EOR, TILE_FIRST, CLS_BOTH);
		send_byte(MODE_REV, 8'd255);
		send_tile(MODE_EOR, TILE_FIRST, CLS_BOTH);
		write_reg(REG_QUAL_BASE, 32'd0);
		write_reg(REG_KEEP_LEVEL, 32'd0);
		send_byte(MODE_FWD, 8'd0);
		send_tile(MODE_EOR, TILE_LAST, CLS_BOTH);
		write_reg(REG_QUAL_BASE, 32'd127);
		write_reg(REG_KEEP_LEVEL, 32'd127);
		send_byte(MODE_FWD, 8'd254);
		send_tile(MODE_EOR, TILE_LAST, CLS_BOTH);
		send_byte(MODE_FWD, 8'd253);
		send_tile(MODE_EOR, TILE_LAST, CLS_BOTH);
		// change the threshold in the middle of a record
		write_reg(REG_SINGLE_END, 32'd0);
		write_reg(REG_QUAL_BASE, 32'd33);
		write_reg(REG_KEEP_LEVEL, 32'd20);
		send_byte(MODE_FWD, 8'd40);
		send_byte(MODE_REV, 8'd60);
		write_reg(REG_KEEP_LEVEL, 32'd0);
		send_byte(MODE_FWD, 8'd50);
		send_byte(MODE_REV, 8'd20);
		send_tile(MODE_EOR, TILE_LAST, CLS_BOTH);
		write_reg(REG_UNMAPPED, 32'h7f);
		send_byte(MODE_FWD, 8'd33);
		send_byte(MODE_REV, 8'd32);
		send_tile(MODE_EOR, TILE_LAST, CLS_BOTH);
		for (int c = 0; c < CLASS_COUNT; c++)
			send_tile(MODE_READ, TILE_LAST, 2'(c));
		write_reg(REG_KEEP_LEVEL, 32'd20);
	endtask

	task automatic test_backpressure();
		quiesce();
		tx_gaps_on   = 1'b0;
		hold_request = 1'b1;
		for (int i = 0; i < 24; i++) begin
			if (i % 2 == 1)
				send_tile(MODE_READ, pool_tile(), 2'($urandom_range(0, 3)));
			else
				send_record(0, $urandom_range(0, 1), 10, pool_tile());
		end
		quiesce();
		tx_gaps_on = 1'b1;
	endtask

	task automatic test_random_records();
		int          sent;
		int          phase_end;
		int          pick;
		int          fwd_len;
		int          rev_len;
		logic [21:0] junk;
		sent      = 0;
		phase_end = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent >= phase_end) begin
				write_reg(REG_SINGLE_END, $urandom_range(0, 1));
				write_reg(REG_QUAL_BASE, pick_level(33));
				write_reg(REG_KEEP_LEVEL, pick_level(20));
				tx_gaps_on = $urandom_range(0, 3) != 0;
				rx_gaps_on = $urandom_range(0, 3) != 0;
				phase_end  = sent + $urandom_range(50, 100);
			end
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				fwd_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
				rev_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
				send_record(fwd_len, rev_len, $urandom_range(2, 30),
					($urandom_range(0, 3) == 0) ? rand_tile() : pool_tile());
				sent += fwd_len + rev_len + 1;
			end else if (pick < 85) begin
				send_tile(MODE_READ, pool_tile(), 2'($urandom_range(0, 3)));
				sent++;
			end else begin
				junk = 22'($urandom);
				send_item(mode_t'($urandom_range(0, 3)), {2'b00, junk});
				sent++;
			end
		end
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
	endtask

	initial begin : receiver
		int stall;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			stall = 0;
			if (hold_request) begin
				hold_request = 1'b0;
				stall = HOLD_CYCLES;
			end else if (rx_gaps_on) begin
				stall = pick_gap();
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: kind %0d decision %0d counter_value %0d",
					m_axis_tuser[0], m_axis_tdata[1:0], m_axis_tdata[33:2]);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tuser[0] !== want.kind) begin
					$error("result_kind: expected %0d, got %0d", want.kind, m_axis_tuser[0]);
					mismatch_count++;
				end
				if (m_axis_tdata[1:0] !== want.decision) begin
					$error("decision: expected %0d, got %0d", want.decision, m_axis_tdata[1:0]);
					mismatch_count++;
				end
				if (m_axis_tdata[33:2] !== want.count) begin
					$error("counter_value: expected %0d, got %0d", want.count,
						m_axis_tdata[33:2]);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("read_pair_mean_quality_filter_core verification failed");
		$finish;
	end

	initial begin : run
		arst_n        <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= MODE_FWD;
		cfg_mirror.single_end = 1'b0;
		cfg_mirror.qual_base  = 7'd33;
		cfg_mirror.keep_level = 7'd20;
		mismatch_count = 0;
		tx_gaps_on     = 1'b1;
		rx_gaps_on     = 1'b1;
		hold_request   = 1'b0;
		tile_pool.push_back(TILE_FIRST);
		tile_pool.push_back(TILE_LAST);
		repeat (6) tile_pool.push_back(rand_tile());
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_classes();
		test_register_settings();
		test_backpressure();
		test_random_records();
		quiesce();
		if (mismatch_count == 0)
			$display("read_pair_mean_quality_filter_core verification clean");
		else
			$display("read_pair_mean_quality_filter_core verification failed");
		$finish;
	end

endmodule

@@ read_pair_mean_quality_filter_core.f @@
rtl/rpmqf_pkg.sv
rtl/rpmqf_ram.sv
rtl/rpmqf_cfg.sv
rtl/rpmqf_front.sv
rtl/rpmqf_queue.sv
rtl/rpmqf_back.sv
rtl/read_pair_mean_quality_filter_core.sv
dv/read_pair_mean_quality_filter_core_test.sv
